FILE: src/sct_pkg.sv
// Shared types and constants for the shell command tokenizer.
// Depends on nothing; sct_lex, sct_obuf and the top file refer to it by scoped names.
`default_nettype none

package sct_pkg;

  // Result event codes
  typedef enum logic [3:0] {
    K_BYTE     = 4'd0,
    K_WEND     = 4'd1,
    K_PIPE     = 4'd2,
    K_OROR     = 4'd3,
    K_AMP      = 4'd4,
    K_ANDAND   = 4'd5,
    K_SEMI     = 4'd6,
    K_LESS     = 4'd7,
    K_GREAT    = 4'd8,
    K_DGREAT   = 4'd9,
    K_ERRGREAT = 4'd10,
    K_END      = 4'd11,
    K_OPEN_SQ  = 4'd12,
    K_OPEN_DQ  = 4'd13
  } kind_t;

  // Lexer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'd0,
    S_WORD  = 4'd1,
    S_TWO   = 4'd2,
    S_PIPE  = 4'd3,
    S_AMP   = 4'd4,
    S_GREAT = 4'd5,
    S_SQ    = 4'd6,
    S_DQ    = 4'd7,
    S_DQ_BS = 4'd8
  } state_t;

  // Bytes with a meaning to the lexer
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Most events one request can cause
  localparam int unsigned RES_MAX = 3;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_out;
    logic       quoted;
    logic       last;
  } res_t;

  // Events produced by one request, in order, with their count
  typedef struct packed {
    logic [1:0]             count;
    res_t [RES_MAX-1:0]     res;
  } batch_t;

endpackage

`default_nettype wire

FILE: src/sct_if.sv
// Valid/ready channel interfaces for the tokenizer's byte input and event output.
// Depends on nothing.
`default_nettype none

interface sct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, output ch, output line_end, input ready);
  modport sink   (input valid, input ch, input line_end, output ready);
endinterface

interface sct_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [7:0] byte_out;
  logic       quoted;
  logic       last;

  modport source (output valid, output kind, output byte_out, output quoted,
                  output last, input ready);
  modport sink   (input valid, input kind, input byte_out, input quoted,
                  input last, output ready);
endinterface

`default_nettype wire

FILE: src/sct_lex.sv
// Input register, lexer state register and the one-step lexer logic.
// Depends on sct_pkg and sct_in_if.
`default_nettype none

module sct_lex (
  input  wire logic           clk,
  input  wire logic           rst_n,
  sct_in_if.sink              in_bus,
  input  wire logic           take,      // result buffer accepts a batch now
  output sct_pkg::batch_t     batch,
  output logic                batch_vld
);

  typedef struct packed {
    logic              hit;
    sct_pkg::res_t     res;
    sct_pkg::state_t   nxt;
  } start_t;

  logic            vld_r;
  logic [7:0]      ch_r;
  logic            eol_r;
  sct_pkg::state_t state_r;
  sct_pkg::state_t state_nxt;
  logic            advance;
  start_t          st;

  function automatic sct_pkg::res_t mk(input sct_pkg::kind_t k, input logic [7:0] b,
                                       input logic q, input logic l);
    sct_pkg::res_t r;
    r.kind     = k;
    r.byte_out = b;
    r.quoted   = q;
    r.last     = l;
    return r;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == sct_pkg::CH_SPACE) || (c == sct_pkg::CH_TAB) ||
           (c == sct_pkg::CH_PIPE)  || (c == sct_pkg::CH_LT)  ||
           (c == sct_pkg::CH_GT)    || (c == sct_pkg::CH_AMP) ||
           (c == sct_pkg::CH_SEMI)  || (c == sct_pkg::CH_SQUOTE) ||
           (c == sct_pkg::CH_DQUOTE);
  endfunction

  // Byte seen between tokens: at most one event
  function automatic start_t start_token(input logic [7:0] c);
    start_t s;
    s.hit = 1'b0;
    s.res = mk(sct_pkg::K_BYTE, 8'h00, 1'b0, 1'b0);
    s.nxt = sct_pkg::S_IDLE;
    case (c)
      sct_pkg::CH_SPACE, sct_pkg::CH_TAB: s.nxt = sct_pkg::S_IDLE;
      sct_pkg::CH_PIPE:   s.nxt = sct_pkg::S_PIPE;
      sct_pkg::CH_AMP:    s.nxt = sct_pkg::S_AMP;
      sct_pkg::CH_GT:     s.nxt = sct_pkg::S_GREAT;
      sct_pkg::CH_SEMI: begin
        s.hit = 1'b1;
        s.res = mk(sct_pkg::K_SEMI, 8'h00, 1'b0, 1'b0);
      end
      sct_pkg::CH_LT: begin
        s.hit = 1'b1;
        s.res = mk(sct_pkg::K_LESS, 8'h00, 1'b0, 1'b0);
      end
      sct_pkg::CH_SQUOTE: s.nxt = sct_pkg::S_SQ;
      sct_pkg::CH_DQUOTE: s.nxt = sct_pkg::S_DQ;
      sct_pkg::CH_TWO:    s.nxt = sct_pkg::S_TWO;
      default: begin
        s.hit = 1'b1;
        s.res = mk(sct_pkg::K_BYTE, c, 1'b0, 1'b0);
        s.nxt = sct_pkg::S_WORD;
      end
    endcase
    return s;
  endfunction

  // Input stage: holds one request until its events move to the result buffer
  assign advance      = vld_r && take;
  assign in_bus.ready = !vld_r || take;
  assign batch_vld    = vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      state_r <= sct_pkg::S_IDLE;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        vld_r <= 1'b1;
      end else if (advance) begin
        vld_r <= 1'b0;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      ch_r  <= in_bus.ch;
      eol_r <= in_bus.line_end;
    end
  end

  // One lexer step: events and next state
  always_comb begin
    st            = start_token(ch_r);
    state_nxt     = state_r;
    batch.count   = 2'd0;
    batch.res[0]  = mk(sct_pkg::K_BYTE, 8'h00, 1'b0, 1'b0);
    batch.res[1]  = mk(sct_pkg::K_BYTE, 8'h00, 1'b0, 1'b0);
    batch.res[2]  = mk(sct_pkg::K_BYTE, 8'h00, 1'b0, 1'b0);
    if (eol_r) begin
      state_nxt = sct_pkg::S_IDLE;
      case (state_r)
        sct_pkg::S_WORD: begin
          batch.res[0] = mk(sct_pkg::K_WEND, 8'h00, 1'b0, 1'b0);
          batch.res[1] = mk(sct_pkg::K_END, 8'h00, 1'b0, 1'b1);
          batch.count  = 2'd2;
        end
        sct_pkg::S_TWO: begin
          batch.res[0] = mk(sct_pkg::K_BYTE, sct_pkg::CH_TWO, 1'b0, 1'b0);
          batch.res[1] = mk(sct_pkg::K_WEND, 8'h00, 1'b0, 1'b0);
          batch.res[2] = mk(sct_pkg::K_END, 8'h00, 1'b0, 1'b1);
          batch.count  = 2'd3;
        end
        sct_pkg::S_PIPE: begin
          batch.res[0] = mk(sct_pkg::K_PIPE, 8'h00, 1'b0, 1'b0);
          batch.res[1] = mk(sct_pkg::K_END, 8'h00, 1'b0, 1'b1);
          batch.count  = 2'd2;
        end
        sct_pkg::S_AMP: begin
          batch.res[0] = mk(sct_pkg::K_AMP, 8'h00, 1'b0, 1'b0);
          batch.res[1] = mk(sct_pkg::K_END, 8'h00, 1'b0, 1'b1);
          batch.count  = 2'd2;
        end
        sct_pkg::S_GREAT: begin
          batch.res[0] = mk(sct_pkg::K_GREAT, 8'h00, 1'b0, 1'b0);
          batch.res[1] = mk(sct_pkg::K_END, 8'h00, 1'b0, 1'b1);
          batch.count  = 2'd2;
        end
        sct_pkg::S_SQ: begin
          batch.res[0] = mk(sct_pkg::K_OPEN_SQ, 8'h00, 1'b0, 1'b1);
          batch.count  = 2'd1;
        end
        sct_pkg::S_DQ, sct_pkg::S_DQ_BS: begin
          batch.res[0] = mk(sct_pkg::K_OPEN_DQ, 8'h00, 1'b0, 1'b1);
          batch.count  = 2'd1;
        end
        default: begin
          batch.res[0] = mk(sct_pkg::K_END, 8'h00, 1'b0, 1'b1);
          batch.count  = 2'd1;
        end
      endcase
    end else begin
      case (state_r)
        sct_pkg::S_WORD: begin
          if (is_sep(ch_r)) begin
            batch.res[0] = mk(sct_pkg::K_WEND, 8'h00, 1'b0, 1'b0);
            batch.res[1] = st.res;
            batch.count  = 2'd1 + {1'b0, st.hit};
            state_nxt    = st.nxt;
          end else begin
            batch.res[0] = mk(sct_pkg::K_BYTE, ch_r, 1'b0, 1'b0);
            batch.count  = 2'd1;
          end
        end
        sct_pkg::S_TWO: begin
          batch.res[0] = mk(sct_pkg::K_BYTE, sct_pkg::CH_TWO, 1'b0, 1'b0);
          if (ch_r == sct_pkg::CH_GT) begin
            batch.res[0] = mk(sct_pkg::K_ERRGREAT, 8'h00, 1'b0, 1'b0);
            batch.count  = 2'd1;
            state_nxt    = sct_pkg::S_IDLE;
          end else if (is_sep(ch_r)) begin
            batch.res[1] = mk(sct_pkg::K_WEND, 8'h00, 1'b0, 1'b0);
            batch.res[2] = st.res;
            batch.count  = 2'd2 + {1'b0, st.hit};
            state_nxt    = st.nxt;
          end else begin
            batch.res[1] = mk(sct_pkg::K_BYTE, ch_r, 1'b0, 1'b0);
            batch.count  = 2'd2;
            state_nxt    = sct_pkg::S_WORD;
          end
        end
        sct_pkg::S_PIPE: begin
          if (ch_r == sct_pkg::CH_PIPE) begin
            batch.res[0] = mk(sct_pkg::K_OROR, 8'h00, 1'b0, 1'b0);
            batch.count  = 2'd1;
            state_nxt    = sct_pkg::S_IDLE;
          end else begin
            batch.res[0] = mk(sct_pkg::K_PIPE, 8'h00, 1'b0, 1'b0);
            batch.res[1] = st.res;
            batch.count  = 2'd1 + {1'b0, st.hit};
            state_nxt    = st.nxt;
          end
        end
        sct_pkg::S_AMP: begin
          if (ch_r == sct_pkg::CH_AMP) begin
            batch.res[0] = mk(sct_pkg::K_ANDAND, 8'h00, 1'b0, 1'b0);
            batch.count  = 2'd1;
            state_nxt    = sct_pkg::S_IDLE;
          end else begin
            batch.res[0] = mk(sct_pkg::K_AMP, 8'h00, 1'b0, 1'b0);
            batch.res[1] = st.res;
            batch.count  = 2'd1 + {1'b0, st.hit};
            state_nxt    = st.nxt;
          end
        end
        sct_pkg::S_GREAT: begin
          if (ch_r == sct_pkg::CH_GT) begin
            batch.res[0] = mk(sct_pkg::K_DGREAT, 8'h00, 1'b0, 1'b0);
            batch.count  = 2'd1;
            state_nxt    = sct_pkg::S_IDLE;
          end else begin
            batch.res[0] = mk(sct_pkg::K_GREAT, 8'h00, 1'b0, 1'b0);
            batch.res[1] = st.res;
            batch.count  = 2'd1 + {1'b0, st.hit};
            state_nxt    = st.nxt;
          end
        end
        sct_pkg::S_SQ: begin
          batch.count = 2'd1;
          if (ch_r == sct_pkg::CH_SQUOTE) begin
            batch.res[0] = mk(sct_pkg::K_WEND, 8'h00, 1'b1, 1'b0);
            state_nxt    = sct_pkg::S_IDLE;
          end else begin
            batch.res[0] = mk(sct_pkg::K_BYTE, ch_r, 1'b0, 1'b0);
          end
        end
        sct_pkg::S_DQ: begin
          if (ch_r == sct_pkg::CH_DQUOTE) begin
            batch.res[0] = mk(sct_pkg::K_WEND, 8'h00, 1'b0, 1'b0);
            batch.count  = 2'd1;
            state_nxt    = sct_pkg::S_IDLE;
          end else if (ch_r == sct_pkg::CH_BSLASH) begin
            state_nxt    = sct_pkg::S_DQ_BS;
          end else begin
            batch.res[0] = mk(sct_pkg::K_BYTE, ch_r, 1'b0, 1'b0);
            batch.count  = 2'd1;
          end
        end
        sct_pkg::S_DQ_BS: begin
          // only a quote or a backslash is unescaped; else keep the backslash
          state_nxt = sct_pkg::S_DQ;
          if ((ch_r == sct_pkg::CH_DQUOTE) || (ch_r == sct_pkg::CH_BSLASH)) begin
            batch.res[0] = mk(sct_pkg::K_BYTE, ch_r, 1'b0, 1'b0);
            batch.count  = 2'd1;
          end else begin
            batch.res[0] = mk(sct_pkg::K_BYTE, sct_pkg::CH_BSLASH, 1'b0, 1'b0);
            batch.res[1] = mk(sct_pkg::K_BYTE, ch_r, 1'b0, 1'b0);
            batch.count  = 2'd2;
          end
        end
        default: begin
          batch.res[0] = st.res;
          batch.count  = {1'b0, st.hit};
          state_nxt    = st.nxt;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/sct_obuf.sv
// Result buffer: holds the events of one request and hands them out one per cycle while out_bus.ready is high.
// Depends on sct_pkg and sct_out_if.
`default_nettype none

module sct_obuf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,      // batch moves in this cycle
  input  wire sct_pkg::batch_t batch,
  output logic                take,      // buffer can accept a batch now
  sct_out_if.source           out_bus
);

  sct_pkg::res_t [sct_pkg::RES_MAX-1:0] res_r;
  logic [1:0]    cnt_r;   // events still to deliver
  logic [1:0]    idx_r;   // next event to deliver
  logic          pop;
  sct_pkg::res_t head;

  assign pop  = (cnt_r != 2'd0) && out_bus.ready;
  assign take = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_bus.ready);
  assign head = res_r[idx_r];

  assign out_bus.valid    = (cnt_r != 2'd0);
  assign out_bus.kind     = head.kind;
  assign out_bus.byte_out = head.byte_out;
  assign out_bus.quoted   = head.quoted;
  assign out_bus.last     = head.last;

  // Count and read pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      cnt_r <= batch.count;
      idx_r <= 2'd0;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
      idx_r <= idx_r + 2'd1;
    end
  end

  // Event payloads
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= batch.res;
    end
  end

endmodule

`default_nettype wire

FILE: src/shell_command_tokenizer.sv
// Streaming shell command line tokenizer: one byte or line end per request in,
// token events out. Depends on sct_pkg, sct_if, sct_lex and sct_obuf.
//
// A request enters an input register; combinational lexer logic turns it into
// zero to three events that move as a group into a result buffer, which
// presents them one per cycle while the consumer is ready. A request causing
// at most one event keeps a rate of one request per cycle while the consumer
// is ready; one causing more holds the next request until the buffer hands out
// the last of them. Each passes the input register, then the result buffer.
// Events of a line stream out before a quote error can be known; an event
// with last set (end, open single, open double) closes the line, and the
// consumer drops the line when it is an open-quote error.
`default_nettype none

module shell_command_tokenizer (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sct_in_if.sink     in_bus,
  sct_out_if.source  out_bus
);

  sct_pkg::batch_t batch;
  logic            batch_vld;
  logic            take;

  sct_lex u_lex (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .take      (take),
    .batch     (batch),
    .batch_vld (batch_vld)
  );

  sct_obuf u_obuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (batch_vld && take),
    .batch   (batch),
    .take    (take),
    .out_bus (out_bus)
  );

  // Only end and open-quote events close a line
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.last) |->
      ((out_bus.kind == sct_pkg::K_END) || (out_bus.kind == sct_pkg::K_OPEN_SQ) ||
       (out_bus.kind == sct_pkg::K_OPEN_DQ)))
    else $error("last set on a non-final event");

  // Byte field is zero except on word bytes
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && (out_bus.kind != sct_pkg::K_BYTE)) |-> (out_bus.byte_out == 8'h00))
    else $error("byte field set on a non-byte event");

  // Quoted flag only on a word end
  a_quoted_wend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.quoted) |-> (out_bus.kind == sct_pkg::K_WEND))
    else $error("quoted flag on an event other than word end");

  // Input stalls only while a request waits for the result buffer
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (batch_vld && !take))
    else $error("input stalled without a waiting request");

endmodule

`default_nettype wire
